// File: hw/rtl/dans_pkg.sv
// Shared types, constants and time helpers for the daily alarm scheduler.
`default_nettype none

package dans_pkg;

    // Fixed time constants.
    localparam int unsigned HOUR_MINUTES    = 60;
    localparam int unsigned DAY_MINUTES     = 24 * HOUR_MINUTES;
    localparam int unsigned DAY_HOURS       = DAY_MINUTES / HOUR_MINUTES;
    localparam int unsigned ZONE_RESET      = 8 * HOUR_MINUTES;
    localparam int unsigned JUMP_RESET      = 2;

    // Table defaults and limits.
    localparam int unsigned TABLE_DEPTH_DEF = 16;
    localparam int unsigned MAX_DUE         = 16;
    localparam int unsigned DUE_W           = $clog2(MAX_DUE + 1);
    localparam int unsigned IDX_IN_W        = 5;
    localparam int unsigned MINUTE_W        = 11;
    localparam int unsigned CFG_IDX_W       = 1;

    // Division by 60 as a multiply by a scaled reciprocal; exact for 0..1439.
    localparam int unsigned DIV60_RECIP     = 1093;
    localparam int unsigned DIV60_SHIFT     = 16;

    localparam logic signed [12:0] DAY_S    = 13'(DAY_MINUTES);
    localparam logic signed [12:0] DAY_S_X2 = 13'(2 * DAY_MINUTES);

    typedef logic [MINUTE_W-1:0] t_minute;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_RELOAD = 3'd3,
        OP_FIRED  = 3'd4,
        OP_TICK   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        KIND_STATUS = 3'd0,
        KIND_DUE    = 3'd1,
        KIND_ARM    = 3'd2,
        KIND_CANCEL = 3'd3,
        KIND_NONE   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZONE_OFFSET    = 1'b0,
        CFG_JUMP_THRESHOLD = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DECODE,
        S_SHIFT,
        S_SCAN,
        S_FIN,
        S_DIVQ,
        S_DIVR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0] operation;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
        logic       title_present;
        logic [4:0] entry_index;
        logic [4:0] clock_hour;
        logic [5:0] clock_minute;
        logic       clock_readable;
        logic       clock_set;
    } t_item;

    typedef struct packed {
        logic signed [10:0] zone_offset;
        logic [10:0]        jump_threshold;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        t_status    status;
        logic [3:0] index;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] count;
        logic       waiting;
        logic       last;
    } t_result;

    function automatic logic [10:0] mul60(input logic [4:0] v);
        return 11'(v) * 11'(HOUR_MINUTES);
    endfunction

    function automatic logic [4:0] div60(input logic [10:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'(DIV60_RECIP);
        return 5'(p >> DIV60_SHIFT);
    endfunction

    // Folds a value in -1440..4319 back into one day.
    function automatic t_minute wrap_day(input logic signed [12:0] v);
        logic signed [12:0] r;
        if (v < 13'sd0) begin
            r = v + DAY_S;
        end else if (v >= DAY_S_X2) begin
            r = v - DAY_S_X2;
        end else if (v >= DAY_S) begin
            r = v - DAY_S;
        end else begin
            r = v;
        end
        return r[MINUTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dans_table.sv
// Reminder time memory: one write port, one read port with registered data.
`default_nettype none

module dans_table #(
    parameter int unsigned DEPTH = dans_pkg::TABLE_DEPTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [AW-1:0]             i_waddr,
    input  wire dans_pkg::t_minute   i_wdata,
    input  wire                      i_re,
    input  wire [AW-1:0]             i_raddr,
    output dans_pkg::t_minute        o_rdata
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dans_pkg::t_minute mem [DEPTH];
    dans_pkg::t_minute r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled consumer keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/dans_ctrl.sv
// Sequencer for the scheduler: decodes operations, walks the table and builds results.
`default_nettype none

module dans_ctrl #(
    parameter int unsigned DEPTH = dans_pkg::TABLE_DEPTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire dans_pkg::t_item    i_item,
    input  wire dans_pkg::t_cfg     i_cfg,
    output logic                    o_res_valid,
    input  wire                     i_res_ready,
    output dans_pkg::t_result       o_res,
    output logic                    o_mem_we,
    output logic [AW-1:0]           o_mem_waddr,
    output dans_pkg::t_minute       o_mem_wdata,
    output logic                    o_mem_re,
    output logic [AW-1:0]           o_mem_raddr,
    input  wire dans_pkg::t_minute  i_mem_rdata
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = (CW > dans_pkg::IDX_IN_W) ? CW : dans_pkg::IDX_IN_W;

    dans_pkg::t_state   r_state, n_state;
    dans_pkg::t_item    r_item;
    dans_pkg::t_result  r_res, n_res;

    logic [CW-1:0]      r_used, n_used;
    logic               r_cur_v, n_cur_v;
    dans_pkg::t_minute  r_cur, n_cur;
    logic               r_arm_v, n_arm_v;
    dans_pkg::t_minute  r_arm, n_arm;
    logic               r_wait, n_wait;
    logic               r_prev_v, n_prev_v;
    dans_pkg::t_minute  r_prev, n_prev;

    logic               r_now_v, n_now_v;
    dans_pkg::t_minute  r_now, n_now;
    logic [4:0]         r_hr, n_hr;
    logic [5:0]         r_mn, n_mn;
    logic               r_fire_on, n_fire_on;
    dans_pkg::t_minute  r_fire_val, n_fire_val;
    logic               r_floor_v, n_floor_v;
    dans_pkg::t_minute  r_floor, n_floor;
    logic               r_gt_v, n_gt_v;
    dans_pkg::t_minute  r_gt, n_gt;
    logic               r_min_v, n_min_v;
    dans_pkg::t_minute  r_min, n_min;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_cidx, n_cidx;
    logic               r_pend, n_pend;
    logic [dans_pkg::DUE_W-1:0] r_due_n, n_due_n;
    dans_pkg::t_minute  r_utc, n_utc;

    dans_pkg::t_op      op;
    logic               accept;
    logic               add_ok, add_room, rm_ok;
    logic               jump, need, do_reload, reload_arm;
    logic [11:0]        tick_d;
    logic               has_more, match, consume, scan_re, walk_done;
    logic               rdata_above;
    logic [CW-1:0]      cidx_m1;
    dans_pkg::t_minute  next_val;
    logic signed [12:0] now_raw, utc_raw;
    dans_pkg::t_kind    d_kind;
    dans_pkg::t_status  d_status;
    logic [3:0]         d_index;

    function automatic dans_pkg::t_result make_res(
        input dans_pkg::t_kind   kind,
        input dans_pkg::t_status status,
        input logic [3:0]        index,
        input logic [4:0]        hour,
        input logic [5:0]        minute,
        input logic [CW-1:0]     count,
        input logic              waiting,
        input logic              last
    );
        dans_pkg::t_result r;
        r.kind    = kind;
        r.status  = status;
        r.index   = index;
        r.hour    = hour;
        r.minute  = minute;
        r.count   = 5'(count);
        r.waiting = waiting;
        r.last    = last;
        return r;
    endfunction

    // Shared decode and walk conditions.
    always_comb begin
        op         = dans_pkg::t_op'(r_item.operation);
        accept     = i_in_valid && (r_state == dans_pkg::S_IDLE);
        add_ok     = r_item.title_present
                     && (r_item.entry_hour <= 5'(dans_pkg::DAY_HOURS - 1))
                     && (r_item.entry_minute <= 6'(dans_pkg::HOUR_MINUTES - 1));
        add_room   = r_used < CW'(DEPTH);
        rm_ok      = IW'(r_item.entry_index) < IW'(r_used);

        tick_d     = {1'b0, r_now} - {1'b0, r_prev};
        if (r_now < r_prev) begin
            tick_d = tick_d + 12'(dans_pkg::DAY_MINUTES);
        end
        jump       = r_now_v && r_prev_v && (tick_d[10:0] > i_cfg.jump_threshold);
        need       = jump || (r_wait && (r_used != '0));
        do_reload  = (op == dans_pkg::OP_RELOAD) || ((op == dans_pkg::OP_TICK) && need);
        reload_arm = do_reload && (r_used != '0) && r_item.clock_set;

        has_more   = r_idx < r_used;
        match      = r_fire_on && (i_mem_rdata == r_fire_val)
                     && (r_due_n < dans_pkg::DUE_W'(dans_pkg::MAX_DUE));
        consume    = r_pend && (!match || i_res_ready);
        scan_re    = has_more && (!r_pend || consume);
        walk_done  = !has_more && !r_pend;
        rdata_above = !r_floor_v || (i_mem_rdata > r_floor);
        cidx_m1    = r_cidx - CW'(1);
        next_val   = r_gt_v ? r_gt : r_min;

        now_raw    = $signed({2'b00, dans_pkg::mul60(r_item.clock_hour)})
                     + $signed({7'b0, r_item.clock_minute})
                     + $signed({{2{i_cfg.zone_offset[10]}}, i_cfg.zone_offset});
        utc_raw    = $signed({2'b00, next_val})
                     - $signed({{2{i_cfg.zone_offset[10]}}, i_cfg.zone_offset});
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dans_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = dans_pkg::S_PREP;
                end
            end
            dans_pkg::S_PREP: begin
                n_state = dans_pkg::S_DECODE;
            end
            dans_pkg::S_DECODE: begin
                if ((op == dans_pkg::OP_REMOVE) && rm_ok) begin
                    n_state = dans_pkg::S_SHIFT;
                end else if ((op == dans_pkg::OP_FIRED) || reload_arm) begin
                    n_state = dans_pkg::S_SCAN;
                end else begin
                    n_state = dans_pkg::S_EMIT;
                end
            end
            dans_pkg::S_SHIFT: begin
                if (walk_done) begin
                    n_state = dans_pkg::S_EMIT;
                end
            end
            dans_pkg::S_SCAN: begin
                if (walk_done) begin
                    n_state = dans_pkg::S_FIN;
                end
            end
            dans_pkg::S_FIN: begin
                n_state = r_min_v ? dans_pkg::S_DIVQ : dans_pkg::S_EMIT;
            end
            dans_pkg::S_DIVQ: begin
                n_state = dans_pkg::S_DIVR;
            end
            dans_pkg::S_DIVR: begin
                n_state = dans_pkg::S_EMIT;
            end
            dans_pkg::S_EMIT: begin
                if (i_res_ready) begin
                    n_state = dans_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dans_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: handshakes, memory ports and the result offered downstream.
    always_comb begin
        o_in_ready  = (r_state == dans_pkg::S_IDLE);
        o_mem_we    = 1'b0;
        o_mem_waddr = r_used[AW-1:0];
        o_mem_wdata = dans_pkg::mul60(r_item.entry_hour) + 11'(r_item.entry_minute);
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];
        o_res_valid = 1'b0;
        o_res       = r_res;
        unique case (r_state)
            dans_pkg::S_DECODE: begin
                o_mem_we = (op == dans_pkg::OP_ADD) && add_ok && add_room;
            end
            dans_pkg::S_SHIFT: begin
                o_mem_we    = r_pend;
                o_mem_waddr = cidx_m1[AW-1:0];
                o_mem_wdata = i_mem_rdata;
                o_mem_re    = has_more;
            end
            dans_pkg::S_SCAN: begin
                o_mem_re    = scan_re;
                o_res_valid = r_pend && match;
                o_res       = make_res(dans_pkg::KIND_DUE, dans_pkg::ST_OK, 4'(r_cidx),
                                       r_hr, r_mn, r_used, r_wait, 1'b0);
            end
            dans_pkg::S_EMIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_res      = r_res;
        n_used     = r_used;
        n_cur_v    = r_cur_v;
        n_cur      = r_cur;
        n_arm_v    = r_arm_v;
        n_arm      = r_arm;
        n_wait     = r_wait;
        n_prev_v   = r_prev_v;
        n_prev     = r_prev;
        n_now_v    = r_now_v;
        n_now      = r_now;
        n_hr       = r_hr;
        n_mn       = r_mn;
        n_fire_on  = r_fire_on;
        n_fire_val = r_fire_val;
        n_floor_v  = r_floor_v;
        n_floor    = r_floor;
        n_gt_v     = r_gt_v;
        n_gt       = r_gt;
        n_min_v    = r_min_v;
        n_min      = r_min;
        n_idx      = r_idx;
        n_cidx     = r_cidx;
        n_pend     = r_pend;
        n_due_n    = r_due_n;
        n_utc      = r_utc;
        d_kind     = dans_pkg::KIND_STATUS;
        d_status   = dans_pkg::ST_OK;
        d_index    = '0;

        case (r_state)
            dans_pkg::S_PREP: begin
                n_now_v = r_item.clock_readable;
                n_now   = dans_pkg::wrap_day(now_raw);
                n_hr    = dans_pkg::div60(r_arm);
            end
            dans_pkg::S_DECODE: begin
                n_mn      = 6'(r_arm - dans_pkg::mul60(r_hr));
                n_idx     = '0;
                n_pend    = 1'b0;
                n_gt_v    = 1'b0;
                n_min_v   = 1'b0;
                n_due_n   = '0;
                n_fire_on = 1'b0;
                if ((op == dans_pkg::OP_TICK) && r_now_v) begin
                    n_prev_v = 1'b1;
                    n_prev   = r_now;
                end
                case (op)
                    dans_pkg::OP_ADD: begin
                        if (!add_ok) begin
                            d_status = dans_pkg::ST_INVALID;
                        end else if (!add_room) begin
                            d_status = dans_pkg::ST_FULL;
                        end else begin
                            d_index = 4'(r_used);
                            n_used  = r_used + CW'(1);
                        end
                    end
                    dans_pkg::OP_REMOVE: begin
                        if (!rm_ok) begin
                            d_status = dans_pkg::ST_INVALID;
                        end else begin
                            n_idx = CW'(r_item.entry_index) + CW'(1);
                        end
                    end
                    dans_pkg::OP_CLEAR: begin
                        n_used  = '0;
                        n_cur_v = 1'b0;
                    end
                    dans_pkg::OP_FIRED: begin
                        n_arm_v    = 1'b0;
                        n_fire_on  = r_arm_v;
                        n_fire_val = r_arm;
                        if (r_arm_v) begin
                            n_cur_v   = 1'b1;
                            n_cur     = r_arm;
                            n_floor_v = 1'b1;
                            n_floor   = r_arm;
                        end else begin
                            n_floor_v = r_cur_v;
                            n_floor   = r_cur;
                        end
                    end
                    dans_pkg::OP_RELOAD, dans_pkg::OP_TICK: begin
                        d_kind = dans_pkg::KIND_NONE;
                        if (do_reload) begin
                            if (r_used == '0) begin
                                d_kind  = dans_pkg::KIND_CANCEL;
                                n_cur_v = 1'b0;
                                n_arm_v = 1'b0;
                                n_wait  = 1'b0;
                            end else if (!r_item.clock_set) begin
                                n_arm_v = 1'b0;
                                n_wait  = 1'b1;
                            end else begin
                                // Floor is the last fired minute, else the current one.
                                n_wait    = 1'b0;
                                n_floor_v = r_cur_v || r_now_v;
                                n_floor   = r_cur_v ? r_cur : r_now;
                            end
                        end
                    end
                    default: begin
                        d_status = dans_pkg::ST_INVALID;
                    end
                endcase
                n_res = make_res(d_kind, d_status, d_index, 5'd0, 6'd0,
                                 n_used, n_wait, 1'b1);
            end
            dans_pkg::S_SHIFT: begin
                if (has_more) begin
                    n_cidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end
                n_pend = has_more;
                if (walk_done) begin
                    n_used = r_used - CW'(1);
                    n_res  = make_res(dans_pkg::KIND_STATUS, dans_pkg::ST_OK, 4'd0, 5'd0,
                                      6'd0, n_used, r_wait, 1'b1);
                end
            end
            dans_pkg::S_SCAN: begin
                if (consume) begin
                    if (rdata_above && (!r_gt_v || (i_mem_rdata < r_gt))) begin
                        n_gt_v = 1'b1;
                        n_gt   = i_mem_rdata;
                    end
                    if (!r_min_v || (i_mem_rdata < r_min)) begin
                        n_min_v = 1'b1;
                        n_min   = i_mem_rdata;
                    end
                    if (match) begin
                        n_due_n = r_due_n + dans_pkg::DUE_W'(1);
                    end
                end
                if (scan_re) begin
                    n_cidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end
                n_pend = scan_re || (r_pend && !consume);
            end
            dans_pkg::S_FIN: begin
                if (r_min_v) begin
                    n_arm_v = 1'b1;
                    n_arm   = next_val;
                    n_utc   = dans_pkg::wrap_day(utc_raw);
                end else begin
                    n_res = make_res(dans_pkg::KIND_NONE, dans_pkg::ST_OK, 4'd0, 5'd0,
                                     6'd0, r_used, r_wait, 1'b1);
                end
            end
            dans_pkg::S_DIVQ: begin
                n_hr = dans_pkg::div60(r_utc);
            end
            dans_pkg::S_DIVR: begin
                n_res = make_res(dans_pkg::KIND_ARM, dans_pkg::ST_OK, 4'd0, r_hr,
                                 6'(r_utc - dans_pkg::mul60(r_hr)), r_used, r_wait, 1'b1);
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dans_pkg::S_IDLE;
            r_used   <= '0;
            r_cur_v  <= 1'b0;
            r_arm_v  <= 1'b0;
            r_wait   <= 1'b0;
            r_prev_v <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cur_v  <= n_cur_v;
            r_arm_v  <= n_arm_v;
            r_wait   <= n_wait;
            r_prev_v <= n_prev_v;
            r_pend   <= n_pend;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_res      <= n_res;
        r_cur      <= n_cur;
        r_arm      <= n_arm;
        r_prev     <= n_prev;
        r_now_v    <= n_now_v;
        r_now      <= n_now;
        r_hr       <= n_hr;
        r_mn       <= n_mn;
        r_fire_on  <= n_fire_on;
        r_fire_val <= n_fire_val;
        r_floor_v  <= n_floor_v;
        r_floor    <= n_floor;
        r_gt_v     <= n_gt_v;
        r_gt       <= n_gt;
        r_min_v    <= n_min_v;
        r_min      <= n_min;
        r_idx      <= n_idx;
        r_cidx     <= n_cidx;
        r_due_n    <= n_due_n;
        r_utc      <= n_utc;
    end

    // A shift writes below the entry it reads, so the two ports never meet.
    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("memory read and write hit the same entry");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dans_pkg::S_SCAN) && r_pend) |-> (r_cidx < r_used))
        else $error("scan looked at an entry beyond the fill count");

    a_armed_in_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_arm_v |-> (r_arm < 11'(dans_pkg::DAY_MINUTES)))
        else $error("armed minute lies outside one day");

    a_due_only_when_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == dans_pkg::KIND_DUE)) |-> (r_fire_on && !o_res.last))
        else $error("due reminder outside a fired alarm or marked last");

    a_used_stable_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dans_pkg::S_SCAN) && $past(r_state == dans_pkg::S_SCAN))
            |-> $stable(r_used))
        else $error("fill count moved during a scan");

endmodule

`default_nettype wire

// File: hw/rtl/daily_alarm_next_event_scheduler_top.sv
// Top level of the daily alarm scheduler: configuration, output register and table.
//
//   Channel   Direction  Handshake                   Payload
//   -------   ---------  --------------------------  ---------------------------------------
//   input     in         i_in_valid / o_in_ready     operation, entry and clock fields
//   output    out        o_out_valid / i_out_ready   kind, status, index, time, count, flags
//   config    in         i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One transaction is handled at a time. Add, clear and rejected operations are decoded
// and answered; a remove also shifts down every entry above the removed one; alarm fired,
// and a reload or a tick with reload that finds the clock set and the table not empty,
// also walk all entries below the fill count, as the entry memory delivers one entry
// per cycle through its single read port while no due reminder is held. Each due
// reminder waits for the output to drain. Reset is synchronous; the memory needs no
// clearing pass after it, since only entries below the fill count are ever read.
`default_nettype none

module daily_alarm_next_event_scheduler_top #(
    parameter int unsigned TABLE_DEPTH = dans_pkg::TABLE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire [2:0]   i_operation,
    input  wire [4:0]   i_entry_hour,
    input  wire [5:0]   i_entry_minute,
    input  wire         i_title_present,
    input  wire [4:0]   i_entry_index,
    input  wire [4:0]   i_clock_hour,
    input  wire [5:0]   i_clock_minute,
    input  wire         i_clock_readable,
    input  wire         i_clock_set,

    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_status,
    output logic [3:0]  o_result_index,
    output logic [4:0]  o_result_hour,
    output logic [5:0]  o_result_minute,
    output logic [4:0]  o_entry_count,
    output logic        o_waiting_for_clock,
    output logic        o_last,

    input  wire         i_cfg_we,
    input  wire [dans_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [10:0]  i_cfg_data
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    dans_pkg::t_cfg     r_cfg;
    dans_pkg::t_item    item;
    dans_pkg::t_result  res;
    dans_pkg::t_result  r_out;
    logic               r_out_v;
    logic               res_valid;
    logic               res_ready;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    dans_pkg::t_minute  mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    dans_pkg::t_minute  mem_rdata;

    // Configuration registers; the zone offset is stored as written, in two's complement.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zone_offset    <= 11'(dans_pkg::ZONE_RESET);
            r_cfg.jump_threshold <= 11'(dans_pkg::JUMP_RESET);
        end else if (i_cfg_we) begin
            unique case (dans_pkg::t_cfg_reg'(i_cfg_index))
                dans_pkg::CFG_ZONE_OFFSET:    r_cfg.zone_offset    <= i_cfg_data;
                dans_pkg::CFG_JUMP_THRESHOLD: r_cfg.jump_threshold <= i_cfg_data;
                default:                      r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        item.operation      = i_operation;
        item.entry_hour     = i_entry_hour;
        item.entry_minute   = i_entry_minute;
        item.title_present  = i_title_present;
        item.entry_index    = i_entry_index;
        item.clock_hour     = i_clock_hour;
        item.clock_minute   = i_clock_minute;
        item.clock_readable = i_clock_readable;
        item.clock_set      = i_clock_set;
    end

    dans_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    dans_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: a new result enters when the slot is empty or being taken,
    // so the sequencer keeps working while a finished result waits downstream.
    assign res_ready = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (res_ready) begin
            r_out_v <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_v;
    assign o_kind              = r_out.kind;
    assign o_status            = r_out.status;
    assign o_result_index      = r_out.index;
    assign o_result_hour       = r_out.hour;
    assign o_result_minute     = r_out.minute;
    assign o_entry_count       = r_out.count;
    assign o_waiting_for_clock = r_out.waiting;
    assign o_last              = r_out.last;

endmodule

`default_nettype wire
